@@ design/accc_pkg.sv @@
// Shared types and constants for the ambient-corrected color classifier.
// No dependencies; every other design file imports this package.
package accc_pkg;

    // Fixed field widths.
    localparam int RAW_W      = 16;
    localparam int CORR_W     = RAW_W + 1;
    localparam int THRESH_W   = 17;
    localparam int COUNT_W    = 3;
    localparam int REF_W      = 48;
    localparam int COLOR_IDX_W = 3;
    localparam int DIST_W     = 18;
    localparam int SUM_W      = 19;
    localparam int CFG_IDX_W  = 4;
    localparam int IN_DATA_W  = 8 * RAW_W;
    localparam int OUT_DATA_W = 24;

    // Default number of reference colors.
    localparam int MAX_COLORS_DEF = 6;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLORS    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REF0      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REF5      = 4'd7;

    // Reset value of the color count register.
    localparam logic [COUNT_W-1:0] COLORS_RESET = 3'd6;

    // Largest reportable distance.
    localparam logic [DIST_W-1:0] DIST_SAT = '1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                   load_in;   // capture a new input beat
        logic                   scan;      // compare one reference color
        logic                   first;     // first compare of this item
        logic [COLOR_IDX_W-1:0] idx;       // reference color being compared
        logic                   load_out;  // move result to output register
    } accc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_empty;
    } accc_stat_t;

endpackage

@@ design/accc_cfg_regs.sv @@
// Configuration register file: threshold, color count and reference colors.
// Depends on accc_pkg.
module accc_cfg_regs #(
    parameter int MAX_COLORS = accc_pkg::MAX_COLORS_DEF
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            cfg_fire,
    input  logic [accc_pkg::CFG_IDX_W-1:0]                  cfg_index,
    input  logic [accc_pkg::REF_W-1:0]                      cfg_data,
    output logic signed [accc_pkg::THRESH_W-1:0]            threshold,
    output logic [accc_pkg::COUNT_W-1:0]                    colors_in_use,
    output logic [MAX_COLORS-1:0][accc_pkg::REF_W-1:0]      ref_colors
);
    import accc_pkg::*;

    logic signed [THRESH_W-1:0]          threshold_reg;
    logic [COUNT_W-1:0]                  colors_reg;
    logic [MAX_COLORS-1:0][REF_W-1:0]    ref_reg;

    // Register writes; indexes beyond the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= '0;
            colors_reg    <= COLORS_RESET;
            ref_reg       <= '0;
        end else if (cfg_fire) begin
            if (cfg_index == REG_THRESHOLD) begin
                threshold_reg <= cfg_data[THRESH_W-1:0];
            end
            if (cfg_index == REG_COLORS) begin
                colors_reg <= cfg_data[COUNT_W-1:0];
            end
            for (int i = 0; i < MAX_COLORS; i++) begin
                if (cfg_index == REG_REF0 + CFG_IDX_W'(i)) begin
                    ref_reg[i] <= cfg_data;
                end
            end
        end
    end

    assign threshold     = threshold_reg;
    assign colors_in_use = colors_reg;
    assign ref_colors    = ref_reg;

endmodule

@@ design/accc_datapath.sv @@
// Datapath: ambient correction, empty check, one L1 distance per cycle,
// running minimum and the output register. Depends on accc_pkg.
module accc_datapath #(
    parameter int MAX_COLORS = accc_pkg::MAX_COLORS_DEF
) (
    input  logic                                            aclk,
    input  accc_pkg::accc_cmd_t                             cmd,
    output accc_pkg::accc_stat_t                            stat,
    input  logic [accc_pkg::IN_DATA_W-1:0]                  in_data,
    input  logic signed [accc_pkg::THRESH_W-1:0]            threshold,
    input  logic [MAX_COLORS-1:0][accc_pkg::REF_W-1:0]      ref_colors,
    output logic [accc_pkg::OUT_DATA_W-1:0]                 out_data,
    output logic                                            out_user
);
    import accc_pkg::*;

    localparam int IDX_W = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;

    logic signed [CORR_W-1:0] corr_r, corr_g, corr_b, corr_c;
    logic signed [CORR_W-1:0] corr_r_reg, corr_g_reg, corr_b_reg;
    logic                     empty_reg;
    logic [REF_W-1:0]         ref_sel;
    logic [CORR_W-1:0]        ad_r, ad_g, ad_b;
    logic [SUM_W-1:0]         l1_sum;
    logic [SUM_W-1:0]         best_reg;
    logic [COLOR_IDX_W-1:0]   best_idx_reg;
    logic [OUT_DATA_W-1:0]    out_data_reg;
    logic                     out_user_reg;

    // Ambient correction of the incoming beat.
    assign corr_r = $signed({1'b0, in_data[4*RAW_W +: RAW_W]})
                  - $signed({1'b0, in_data[0*RAW_W +: RAW_W]});
    assign corr_g = $signed({1'b0, in_data[5*RAW_W +: RAW_W]})
                  - $signed({1'b0, in_data[1*RAW_W +: RAW_W]});
    assign corr_b = $signed({1'b0, in_data[6*RAW_W +: RAW_W]})
                  - $signed({1'b0, in_data[2*RAW_W +: RAW_W]});
    assign corr_c = $signed({1'b0, in_data[7*RAW_W +: RAW_W]})
                  - $signed({1'b0, in_data[3*RAW_W +: RAW_W]});

    // Capture corrected channels and the empty decision.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            corr_r_reg <= corr_r;
            corr_g_reg <= corr_g;
            corr_b_reg <= corr_b;
            empty_reg  <= !(corr_c > threshold);
        end
    end

    assign stat.is_empty = empty_reg;

    // Absolute difference of one unsigned reference channel and a corrected value.
    function automatic logic [CORR_W-1:0] abs_diff(input logic [RAW_W-1:0] refc,
                                                   input logic signed [CORR_W-1:0] c);
        logic signed [CORR_W:0] d;
        d = $signed({2'b00, refc}) - $signed({c[CORR_W-1], c});
        abs_diff = d[CORR_W] ? CORR_W'(-d) : d[CORR_W-1:0];
    endfunction

    // L1 distance to the selected reference color.
    assign ref_sel = ref_colors[cmd.idx[IDX_W-1:0]];
    assign ad_r    = abs_diff(ref_sel[47:32], corr_r_reg);
    assign ad_g    = abs_diff(ref_sel[31:16], corr_g_reg);
    assign ad_b    = abs_diff(ref_sel[15:0],  corr_b_reg);
    assign l1_sum  = SUM_W'(ad_r) + SUM_W'(ad_g) + SUM_W'(ad_b);

    // Running minimum; a strict compare keeps the lowest index on ties.
    always_ff @(posedge aclk) begin
        if (cmd.scan && (cmd.first || l1_sum < best_reg)) begin
            best_reg     <= l1_sum;
            best_idx_reg <= cmd.idx;
        end
    end

    // Output register, saturating the reported distance.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if (empty_reg) begin
                out_user_reg <= 1'b1;
                out_data_reg <= '0;
            end else begin
                out_user_reg <= 1'b0;
                out_data_reg <= {3'b000,
                                 best_reg[SUM_W-1] ? DIST_SAT : best_reg[DIST_W-1:0],
                                 best_idx_reg};
            end
        end
    end

    assign out_data = out_data_reg;
    assign out_user = out_user_reg;

endmodule

@@ design/accc_ctrl.sv @@
// Controller: sequences capture, the per-color scan and the output handoff.
// Depends on accc_pkg.
module accc_ctrl #(
    parameter int MAX_COLORS = accc_pkg::MAX_COLORS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    output logic                             m_valid,
    input  logic                             m_ready,
    input  logic [accc_pkg::COUNT_W-1:0]     colors_in_use,
    input  accc_pkg::accc_stat_t             stat,
    output accc_pkg::accc_cmd_t              cmd
);
    import accc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [COLOR_IDX_W-1:0] k_reg, k_next;
    logic                   m_valid_reg, m_valid_next;
    logic [COLOR_IDX_W-1:0] n_eff;
    logic                   s_fire;
    logic                   out_free;
    logic                   last;

    // Effective color count: zero counts as one, the top is clamped.
    always_comb begin
        if (colors_in_use == '0) begin
            n_eff = COLOR_IDX_W'(1);
        end else if (colors_in_use > COLOR_IDX_W'(MAX_COLORS)) begin
            n_eff = COLOR_IDX_W'(MAX_COLORS);
        end else begin
            n_eff = colors_in_use;
        end
    end

    assign s_fire   = s_valid && (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign last     = (k_reg == n_eff - COLOR_IDX_W'(1));

    // Next state and commands.
    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.idx      = k_reg;
        cmd.first    = (k_reg == '0);
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    k_next      = '0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (stat.is_empty) begin
                    state_next = S_DONE;
                end else begin
                    cmd.scan = 1'b1;
                    if (last) begin
                        state_next = S_DONE;
                    end else begin
                        k_next = k_reg + COLOR_IDX_W'(1);
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // The result register is never overwritten while it still holds an untaken beat.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");

    // The scan index stays within the colors in use.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan |-> (k_reg < n_eff))
        else $error("scan index beyond colors in use");

    // An accepted beat always starts a scan.
    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg == S_SCAN && k_reg == '0))
        else $error("accepted beat did not start a scan");

endmodule

@@ design/ambient_corrected_color_classifier_core.sv @@
// Top level of the ambient-corrected nearest-color classifier.
// Depends on accc_pkg, accc_cfg_regs, accc_datapath and accc_ctrl.
//
//  Channel   Direction  Handshake              Payload
//  s_axis    in         s_axis_tvalid/tready   tdata: eight 16-bit raw counts
//  m_axis    out        m_axis_tvalid/tready   tdata: index, distance; tuser: empty
//  cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// A beat goes through capture, one compare per color in use, then the output load.
// An empty reading skips the compares.
// Reset is synchronous and active low; it restores the register defaults.
// A new beat is accepted while an earlier result waits in the output register;
// the handoff waits there until the output side is free.
module ambient_corrected_color_classifier_core #(
    parameter int MAX_COLORS = accc_pkg::MAX_COLORS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // ambient r,g,b,c then lit r,g,b,c, 16 bits each from bit 0 up
    input  logic [accc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // color_index [2:0], best_distance [20:3], zero fill [23:21]
    output logic [accc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // is_empty [0]
    output logic                               m_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [accc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [accc_pkg::REF_W-1:0]         cfg_data
);
    import accc_pkg::*;

    accc_cmd_t                        cmd;
    accc_stat_t                       stat;
    logic signed [THRESH_W-1:0]       threshold;
    logic [COUNT_W-1:0]               colors_in_use;
    logic [MAX_COLORS-1:0][REF_W-1:0] ref_colors;

    // Registers take a write in any cycle.
    assign cfg_ready = 1'b1;

    accc_cfg_regs #(
        .MAX_COLORS (MAX_COLORS)
    ) u_regs (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_fire      (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .threshold     (threshold),
        .colors_in_use (colors_in_use),
        .ref_colors    (ref_colors)
    );

    accc_ctrl #(
        .MAX_COLORS (MAX_COLORS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_axis_tvalid),
        .s_ready       (s_axis_tready),
        .m_valid       (m_axis_tvalid),
        .m_ready       (m_axis_tready),
        .colors_in_use (colors_in_use),
        .stat          (stat),
        .cmd           (cmd)
    );

    accc_datapath #(
        .MAX_COLORS (MAX_COLORS)
    ) u_dp (
        .aclk       (aclk),
        .cmd        (cmd),
        .stat       (stat),
        .in_data    (s_axis_tdata),
        .threshold  (threshold),
        .ref_colors (ref_colors),
        .out_data   (m_axis_tdata),
        .out_user   (m_axis_tuser)
    );

endmodule

@@ test/tb.sv @@
// Self-checking bench for ambient_corrected_color_classifier_core: nearest-color
// prediction with L1 distance, corner readings, then random readings under idling.
// Depends on accc_pkg and the design files under design/.
module tb;
    import accc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int CORR_MAX      = 65535;

    // One input beat; the last member lands in the lowest bits of tdata.
    typedef struct packed {
        logic [RAW_W-1:0] lit_clear;
        logic [RAW_W-1:0] lit_blue;
        logic [RAW_W-1:0] lit_green;
        logic [RAW_W-1:0] lit_red;
        logic [RAW_W-1:0] amb_clear;
        logic [RAW_W-1:0] amb_blue;
        logic [RAW_W-1:0] amb_green;
        logic [RAW_W-1:0] amb_red;
    } reading_t;

    // One classification result.
    typedef struct packed {
        logic                   is_empty;
        logic [COLOR_IDX_W-1:0] color_idx;
        logic [DIST_W-1:0]      distance;
    } verdict_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [REF_W-1:0]      cfg_data = '0;

    // Bench copy of the register file.
    int                    threshold_copy = 0;
    logic [COUNT_W-1:0]    colors_copy = COLORS_RESET;
    logic [REF_W-1:0]      palette_copy [MAX_COLORS_DEF];

    verdict_t pending_verdicts [$];
    verdict_t got_verdict, want_verdict;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int n_errors = 0;
    int n_readings = 0;
    int n_results = 0;
    int n_empty = 0;
    int n_saturated = 0;
    int n_writes = 0;
    int cycle_count = 0;

    ambient_corrected_color_classifier_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still owed",
                     cycle_count, pending_verdicts.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Output side stalls at random.
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare every result beat with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got_verdict.is_empty  = m_axis_tuser;
            got_verdict.color_idx = m_axis_tdata[COLOR_IDX_W-1:0];
            got_verdict.distance  = m_axis_tdata[COLOR_IDX_W +: DIST_W];
            n_results++;
            if (pending_verdicts.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, expected none, got %h",
                         $time, got_verdict);
            end else begin
                want_verdict = pending_verdicts.pop_front();
                if (got_verdict.is_empty !== want_verdict.is_empty) begin
                    n_errors++;
                    $display("%0t: is_empty expected %0d, got %0d", $time,
                             want_verdict.is_empty, got_verdict.is_empty);
                end
                if (got_verdict.color_idx !== want_verdict.color_idx) begin
                    n_errors++;
                    $display("%0t: color_index expected %0d, got %0d", $time,
                             want_verdict.color_idx, got_verdict.color_idx);
                end
                if (got_verdict.distance !== want_verdict.distance) begin
                    n_errors++;
                    $display("%0t: best_distance expected %0d, got %0d", $time,
                             want_verdict.distance, got_verdict.distance);
                end
            end
        end
    end

    function automatic int abs_gap(int a, int b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Zero behaves as one and values above the table size are clamped.
    function automatic int active_colors();
        int n;
        n = colors_copy;
        if (n < 1) n = 1;
        if (n > MAX_COLORS_DEF) n = MAX_COLORS_DEF;
        return n;
    endfunction

    // Predict the classification of one reading under the current registers.
    function automatic verdict_t classify_reading(reading_t r);
        verdict_t v;
        int cr, cg, cb, cc, d, best, best_k;
        cr = int'(r.lit_red) - int'(r.amb_red);
        cg = int'(r.lit_green) - int'(r.amb_green);
        cb = int'(r.lit_blue) - int'(r.amb_blue);
        cc = int'(r.lit_clear) - int'(r.amb_clear);
        v = '0;
        if (cc <= threshold_copy) begin
            v.is_empty = 1'b1;
            return v;
        end
        best = 0;
        best_k = 0;
        for (int k = 0; k < active_colors(); k++) begin
            d = abs_gap(int'(palette_copy[k][47:32]), cr)
              + abs_gap(int'(palette_copy[k][31:16]), cg)
              + abs_gap(int'(palette_copy[k][15:0]), cb);
            // Strict compare keeps the lowest index on ties.
            if (k == 0 || d < best) begin
                best = d;
                best_k = k;
            end
        end
        v.color_idx = COLOR_IDX_W'(best_k);
        v.distance = (best > int'(DIST_SAT)) ? DIST_SAT : DIST_W'(best);
        return v;
    endfunction

    function automatic logic [REF_W-1:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic int clamp_corr(int v);
        if (v > CORR_MAX) return CORR_MAX;
        if (v < -CORR_MAX) return -CORR_MAX;
        return v;
    endfunction

    function automatic int rand_corr();
        return int'($urandom_range(2 * CORR_MAX)) - CORR_MAX;
    endfunction

    // Raw counts {lit, ambient} whose difference is t, ambient level random.
    function automatic logic [2*RAW_W-1:0] raw_pair(int t);
        int a;
        if (t >= 0) a = $urandom_range(CORR_MAX - t);
        else a = -t + int'($urandom_range(CORR_MAX + t));
        return {RAW_W'(a + t), RAW_W'(a)};
    endfunction

    function automatic reading_t reading_from(int cr, int cg, int cb, int cc);
        reading_t r;
        {r.lit_red, r.amb_red}     = raw_pair(cr);
        {r.lit_green, r.amb_green} = raw_pair(cg);
        {r.lit_blue, r.amb_blue}   = raw_pair(cb);
        {r.lit_clear, r.amb_clear} = raw_pair(cc);
        return r;
    endfunction

    // Mostly readings close to a reference color and above threshold,
    // plus threshold-boundary readings and fully random raw counts.
    function automatic reading_t random_reading();
        reading_t r;
        int k, lo, cc, span;
        int ch [3];
        case ($urandom_range(9))
            0, 1: r = {$urandom, $urandom, $urandom, $urandom};
            2: r = reading_from(rand_corr(), rand_corr(), rand_corr(),
                                clamp_corr(threshold_copy + int'($urandom_range(2)) - 1));
            default: begin
                k = $urandom_range(active_colors() - 1);
                span = $urandom_range(1) ? 32 : 4096;
                for (int i = 0; i < 3; i++) begin
                    ch[i] = int'(palette_copy[k][32 - 16 * i +: 16])
                          + int'($urandom_range(2 * span)) - span;
                    if ($urandom_range(5) == 0) ch[i] = int'(palette_copy[k][32 - 16 * i +: 16]);
                    ch[i] = clamp_corr(ch[i]);
                end
                lo = (threshold_copy + 1 > -CORR_MAX) ? threshold_copy + 1 : -CORR_MAX;
                cc = (lo > CORR_MAX) ? CORR_MAX : lo + int'($urandom_range(CORR_MAX - lo));
                r = reading_from(ch[0], ch[1], ch[2], cc);
            end
        endcase
        return r;
    endfunction

    // Send one reading beat and record its prediction on acceptance.
    task automatic send_reading(reading_t r);
        verdict_t v;
        s_axis_tdata  <= r;
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        v = classify_reading(r);
        pending_verdicts.push_back(v);
        n_readings++;
        if (v.is_empty) n_empty++;
        if (!v.is_empty && v.distance == DIST_SAT) n_saturated++;
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
    endtask

    // Stop sending until every owed result has come back.
    task automatic hold_input();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_verdicts.size() != 0) @(posedge aclk);
    endtask

    // Drain and give the pipeline time to go idle before register writes.
    task automatic quiesce();
        hold_input();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Configuration beat; valid stays high until end_config.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REF_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        n_writes++;
        if (idx == REG_THRESHOLD) begin
            threshold_copy = $signed(val[THRESH_W-1:0]);
        end else if (idx == REG_COLORS) begin
            colors_copy = val[COUNT_W-1:0];
        end else if (idx >= REG_REF0 && idx <= REG_REF5) begin
            palette_copy[idx - REG_REF0] = val;
        end
    endtask

    task automatic end_config();
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Upper data bits carry junk; only the low register bits matter.
    task automatic write_threshold(int t);
        logic [REF_W-1:0] val;
        val = rand48();
        val[THRESH_W-1:0] = THRESH_W'(t);
        write_reg(REG_THRESHOLD, val);
    endtask

    task automatic write_colors(int n);
        logic [REF_W-1:0] val;
        val = rand48();
        val[COUNT_W-1:0] = COUNT_W'(n);
        write_reg(REG_COLORS, val);
    endtask

    task automatic write_ref(int k, int red, int green, int blue);
        write_reg(REG_REF0 + CFG_IDX_W'(k), {16'(red), 16'(green), 16'(blue)});
    endtask

    task automatic randomize_setup();
        logic [REF_W-1:0] c;
        case ($urandom_range(9))
            0: write_threshold(-65536);
            1: write_threshold(CORR_MAX);
            2: write_threshold(-CORR_MAX);
            3: write_threshold(int'($urandom_range(131071)) - 65536);
            default: write_threshold(int'($urandom_range(4000)) - 2000);
        endcase
        write_colors($urandom_range(7));
        for (int k = 0; k < MAX_COLORS_DEF; k++) begin
            // Duplicate entries force ties between neighbors.
            c = (k > 0 && $urandom_range(3) == 0) ? palette_copy[k - 1] : rand48();
            write_reg(REG_REF0 + CFG_IDX_W'(k), c);
        end
        end_config();
    endtask

    // Defaults after reset: threshold zero, six colors, all at black.
    task automatic test_reset_state();
        send_reading(reading_from(0, 0, 0, 0));
        send_reading(reading_from(5, 6, 7, 1));
        send_reading(reading_from(CORR_MAX, CORR_MAX, CORR_MAX, CORR_MAX));
        send_reading(reading_from(-CORR_MAX, -CORR_MAX, -CORR_MAX, CORR_MAX));
        quiesce();
    endtask

    // Ties, clamped color counts, saturation, threshold limits, bad indexes.
    task automatic test_corner_cases();
        write_threshold(-65536);
        write_colors(7);
        write_ref(0, CORR_MAX, CORR_MAX, CORR_MAX);
        write_ref(1, 0, 0, 0);
        write_ref(2, 100, 200, 300);
        write_ref(3, 100, 200, 300);
        write_ref(4, 1000, 0, 0);
        write_ref(5, 0, 0, 1000);
        end_config();
        send_reading(reading_from(100, 200, 300, -CORR_MAX));
        send_reading(reading_from(-CORR_MAX, -CORR_MAX, -CORR_MAX, 0));
        send_reading(reading_from(CORR_MAX, CORR_MAX, CORR_MAX, CORR_MAX));
        send_reading(reading_from(500, 0, 500, 1));
        send_reading(reading_from(1000, 0, 0, 7));
        quiesce();

        // A count of zero compares entry zero only; farthest corner saturates.
        write_colors(0);
        end_config();
        send_reading(reading_from(-CORR_MAX, -CORR_MAX, -CORR_MAX, 5));
        send_reading(reading_from(CORR_MAX, CORR_MAX, CORR_MAX, 5));
        quiesce();

        // Highest threshold: nothing can be present.
        write_threshold(CORR_MAX);
        end_config();
        send_reading(reading_from(CORR_MAX, 0, 0, CORR_MAX));
        quiesce();

        // Lowest reachable clear value on either side of the threshold.
        write_threshold(-CORR_MAX);
        write_colors(6);
        end_config();
        send_reading(reading_from(1, 2, 3, -CORR_MAX));
        send_reading(reading_from(1, 2, 3, -CORR_MAX + 1));
        quiesce();

        // Writes past the last register must change nothing.
        for (int i = int'(REG_REF5) + 1; i < (1 << CFG_IDX_W); i++) begin
            write_reg(CFG_IDX_W'(i), rand48());
        end
        end_config();
        send_reading(reading_from(1, 2, 3, 0));
        send_reading(reading_from(999, 1, 2, 0));
        quiesce();
    endtask

    // Random readings in chunks, each chunk under a fresh register setting.
    task automatic run_random_phase(int n_items, int snd_pct, int rcv_pct);
        int done;
        int chunk;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        done = 0;
        while (done < n_items) begin
            quiesce();
            randomize_setup();
            chunk = $urandom_range(140, 60);
            for (int i = 0; i < chunk && done < n_items; i++) begin
                send_reading(random_reading());
                done++;
                if ($urandom_range(79) == 0) hold_input();
            end
        end
        quiesce();
    endtask

    initial begin
        for (int k = 0; k < MAX_COLORS_DEF; k++) palette_copy[k] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_corner_cases();
        run_random_phase(430, 34, 79);
        run_random_phase(430, 79, 34);
        run_random_phase(430, 0, 0);
        quiesce();

        $display("Classified %0d readings (%0d empty, %0d at saturated distance),",
                 n_readings, n_empty, n_saturated);
        $display("checked %0d results across %0d register writes.", n_results, n_writes);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
